/* sv/assert_macros.svh */
// Assertion macros used by the port-level checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check with reset disable.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication check with reset disable.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/art_pkg.sv */
// Package for the access rights table: sizes, mode, status, config and rights codes,
// and the command and status structs between controller and datapath. No dependencies.
package art_pkg;

  localparam int unsigned ENTRIES_DEF      = 64;
  localparam int unsigned MAX_SUBJECTS_DEF = 16;
  localparam int unsigned MAX_OBJECTS_DEF  = 16;

  localparam int unsigned CFG_W = 5;
  localparam int unsigned LIST_MAX = 16;

  // Command modes
  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_REM  = 3'd1;
  localparam logic [2:0] MODE_NEW  = 3'd2;
  localparam logic [2:0] MODE_DEL  = 3'd3;
  localparam logic [2:0] MODE_OCC  = 3'd4;
  localparam logic [2:0] MODE_LIST = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NEW  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Config register indexes
  localparam logic CFG_INIT_SUBJ = 1'b0;
  localparam logic CFG_OBJ_CNT   = 1'b1;

  // Rights bits
  localparam logic [1:0] RIGHTS_RW = 2'b11;

  // Controller commands to the datapath
  typedef struct packed {
    logic start;    // latch item, clear scan state
    logic scan;     // process entry at read index
    logic append;   // write new entry at end
    logic finish;   // apply end-of-command updates
    logic emit;     // pop next listed subject
  } art_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic scan_done;  // read index reached count
    logic list_left;  // listed subjects remain to be sent
  } art_sts_t;

endpackage

/* sv/art_datapath.sv */
// Datapath of the access rights table: entry memory, counts, scan logic.
// Depends on art_pkg.
module art_datapath
  import art_pkg::*;
#(
  parameter int unsigned ENTRIES      = ENTRIES_DEF,
  parameter int unsigned MAX_SUBJECTS = MAX_SUBJECTS_DEF,
  parameter int unsigned MAX_OBJECTS  = MAX_OBJECTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic [2:0]       mode_i,
  input  logic [3:0]       subject_index_i,
  input  logic [3:0]       object_index_i,
  input  logic [1:0]       rights_mask_i,
  input  art_cmd_t         cmd_i,
  output art_sts_t         sts_o,
  output logic [1:0]       status_o,
  output logic [4:0]       subject_out_o,
  output logic [4:0]       row_count_o,
  output logic [8:0]       cell_count_o,
  output logic [6:0]       filled_count_o,
  output logic             last_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned LW = $clog2(LIST_MAX + 1);

  typedef struct packed {
    logic [3:0] subj;
    logic [3:0] obj;
    logic [1:0] rights;
  } entry_t;

  entry_t mem [ENTRIES];
  entry_t rd_data_q;         // registered read, one entry ahead of the scan
  logic [AW-1:0] rd_addr;

  logic [CW-1:0] count_q;
  logic [CW-1:0] rd_q;     // read pointer
  logic [CW-1:0] wr_q;     // compaction write pointer
  logic [MAX_SUBJECTS-1:0] del_q;
  logic [4:0] added_q;
  logic [CFG_W-1:0] init_subj_q, obj_cnt_q;

  logic [2:0] mode_q;
  logic [3:0] subj_q, obj_q;
  logic [1:0] mask_q;
  logic       found_q;
  logic [4:0] rows_q;
  logic [1:0] status_q;
  logic [4:0] subj_out_q;

  logic [3:0] list_q [LIST_MAX];
  logic [LW-1:0] list_n_q, list_i_q;

  // Saturated subject total
  logic [5:0] tot_raw;
  logic [4:0] total;
  assign tot_raw = {1'b0, init_subj_q} + {1'b0, added_q};
  assign total = (tot_raw > 6'(MAX_SUBJECTS)) ? 5'(MAX_SUBJECTS) : tot_raw[4:0];

  entry_t e;
  logic   e_sub_hit, e_hit, e_keep;
  logic [1:0] e_new_rights;
  logic   in_list;
  assign e = rd_data_q;
  assign e_sub_hit = (e.subj == subj_q);
  assign e_hit = e_sub_hit && (e.obj == obj_q);

  // Entry 0 is fetched on start, then the next entry on every scan step
  assign rd_addr = cmd_i.start ? '0 : AW'(rd_q + CW'(1));

  // New rights and keep decision for the entry under scan
  always_comb begin
    e_new_rights = e.rights;
    e_keep = 1'b1;
    unique case (mode_q)
      MODE_ADD: if (e_hit && !found_q) e_new_rights = e.rights | mask_q;
      MODE_REM: if (e_hit && !found_q) begin
        e_new_rights = e.rights & ~mask_q & RIGHTS_RW;
        e_keep = (e_new_rights != 2'b00);
      end
      MODE_DEL: e_keep = !e_sub_hit;
      default: ;
    endcase
  end

  always_comb begin
    in_list = 1'b0;
    for (int j = 0; j < LIST_MAX; j++)
      if (LW'(j) < list_n_q && list_q[j] == e.subj) in_list = 1'b1;
  end

  // Entry memory: compaction rewrite during scan, append on add.
  // Writes land at or below the scan position, reads run one ahead.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && e_keep)
      mem[wr_q[AW-1:0]] <= '{subj: e.subj, obj: e.obj, rights: e_new_rights};
    else if (cmd_i.append)
      mem[count_q[AW-1:0]] <= '{subj: subj_q, obj: obj_q, rights: mask_q};
    rd_data_q <= mem[rd_addr];
  end

  logic sub_ok;
  assign sub_ok = ({1'b0, subj_q} < total) &&
                  !((32'(subj_q) < MAX_SUBJECTS) && del_q[subj_q]);

  logic [8:0] cells;
  logic [CFG_W-1:0] objs;
  always_comb begin
    objs = (obj_cnt_q > CFG_W'(MAX_OBJECTS)) ? CFG_W'(MAX_OBJECTS) : obj_cnt_q;
    cells = 9'(rows_q * objs);
  end

  // Status and subject count decided at the end of a command
  logic [1:0] fin_status;
  logic [4:0] fin_subj_out;
  always_comb begin
    fin_status = ST_NONE;
    fin_subj_out = '0;
    unique case (mode_q)
      MODE_ADD:
        if (found_q) fin_status = ST_DONE;
        else if (sub_ok) begin
          if (mask_q == 2'b00) fin_status = ST_DONE;
          else if (count_q >= CW'(ENTRIES)) fin_status = ST_FULL;
          else fin_status = ST_NEW;
        end
      MODE_REM: if (found_q) fin_status = ST_DONE;
      MODE_NEW:
        if (32'(total) >= MAX_SUBJECTS) begin
          fin_status = ST_FULL; fin_subj_out = total;
        end else begin
          fin_status = ST_DONE;
          fin_subj_out = (tot_raw + 6'd1 > 6'(MAX_SUBJECTS)) ?
                         5'(MAX_SUBJECTS) : 5'(tot_raw + 6'd1);
        end
      MODE_DEL: if (found_q) fin_status = ST_DONE;
      MODE_OCC: fin_status = ST_DONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; rd_q <= '0; wr_q <= '0; del_q <= '0; added_q <= '0;
      init_subj_q <= 5'd2; obj_cnt_q <= 5'd2;
      found_q <= 1'b0; rows_q <= '0; list_n_q <= '0; list_i_q <= '0;
      mode_q <= '0; status_q <= ST_DONE; subj_out_q <= '0;
      subj_q <= '0; obj_q <= '0; mask_q <= '0;
      list_q <= '{default: '0};
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_INIT_SUBJ) init_subj_q <= cfg_data_i;
        else obj_cnt_q <= cfg_data_i;
      end
      if (cmd_i.start) begin
        mode_q <= mode_i; subj_q <= subject_index_i;
        obj_q <= object_index_i; mask_q <= rights_mask_i;
        rd_q <= '0; wr_q <= '0; found_q <= 1'b0; rows_q <= '0;
        list_n_q <= '0; list_i_q <= '0;
      end
      if (cmd_i.scan) begin
        rd_q <= rd_q + CW'(1);
        if (e_keep) wr_q <= wr_q + CW'(1);
        if ((mode_q == MODE_DEL) ? e_sub_hit : e_hit) found_q <= 1'b1;
        if (5'(e.subj) + 5'd1 > rows_q) rows_q <= 5'(e.subj) + 5'd1;
        if (mode_q == MODE_LIST && e.obj == obj_q && !in_list &&
            list_n_q < LW'(LIST_MAX)) begin
          list_q[list_n_q[LW-2:0]] <= e.subj;
          list_n_q <= list_n_q + LW'(1);
        end
      end
      if (cmd_i.append) count_q <= count_q + CW'(1);
      if (cmd_i.finish) begin
        status_q <= fin_status;
        subj_out_q <= fin_subj_out;
        if ((mode_q == MODE_REM || mode_q == MODE_DEL) && found_q) count_q <= wr_q;
        if (mode_q == MODE_NEW && fin_status == ST_DONE) added_q <= added_q + 5'd1;
        if (mode_q == MODE_DEL && found_q && 32'(subj_q) < MAX_SUBJECTS)
          del_q[subj_q] <= 1'b1;
      end
      if (cmd_i.emit) list_i_q <= list_i_q + LW'(1);
    end
  end

  // Result fields
  logic is_list, is_occ;
  assign is_list = (mode_q == MODE_LIST) && (list_n_q != '0);
  assign is_occ  = (mode_q == MODE_OCC);
  assign status_o = is_list ? ST_DONE : status_q;
  assign subject_out_o = is_list ? 5'(list_q[list_i_q[LW-2:0]]) : subj_out_q;
  assign row_count_o = is_occ ? rows_q : '0;
  assign cell_count_o = is_occ ? cells : '0;
  assign filled_count_o = is_occ ? 7'(count_q) : '0;
  assign last_o = !is_list || (list_i_q + LW'(1) == list_n_q);

  assign sts_o.scan_done = (rd_q == count_q);
  assign sts_o.list_left = is_list && (list_i_q + LW'(1) != list_n_q);

endmodule

/* sv/art_ctrl.sv */
// Controller of the access rights table: sequences scan, append and
// result transfers. Depends on art_pkg.
module art_ctrl
  import art_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] mode_i,
  input  logic [1:0] status_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  art_sts_t   sts_i,
  output art_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_APP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] mode_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.start = 1'b1; state_d = S_SCAN;
      end
      S_SCAN:
        if (sts_i.scan_done) state_d = S_FIN;
        else cmd_o.scan = 1'b1;
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = (mode_q == MODE_ADD) ? S_APP : S_OUT;
      end
      S_APP: begin
        if (status_i == ST_NEW) cmd_o.append = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) begin
        if (sts_i.list_left) cmd_o.emit = 1'b1;
        else state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; mode_q <= MODE_ADD;
    end else begin
      state_q <= state_d;
      if (cmd_o.start) mode_q <= mode_i;
    end
  end

endmodule

/* sv/access_rights_table_unit.sv */
// Top level of the access rights table: controller plus datapath.
// Depends on art_pkg, art_ctrl, art_datapath.
//
// One command is handled at a time. Each command scans the stored entries
// once, one entry per cycle, compacting in place. After a command is
// taken, the controller steps through the scan, a finish state, an append
// state for an add only, and the result state; a list command sends one
// result per distinct subject, and the unit goes back to idle after the
// last result. The entry memory has one registered read port that fetches
// one entry ahead of the scan and one write port for compaction and append.
// No clearing pass is needed after reset.
module access_rights_table_unit
  import art_pkg::*;
#(
  parameter int unsigned ENTRIES      = ENTRIES_DEF,
  parameter int unsigned MAX_SUBJECTS = MAX_SUBJECTS_DEF,
  parameter int unsigned MAX_OBJECTS  = MAX_OBJECTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // mode, subject_index, object_index, rights_mask
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // status, subject_out, row_count, cell_count,
                                          // filled_count
  output logic             m_axis_tlast
);

  art_cmd_t cmd;
  art_sts_t sts;
  logic [1:0] status;
  logic [4:0] subj_out, rows;
  logic [8:0] cells;
  logic [6:0] filled;

  art_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tdata[2:0]), .status_i(status),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  art_datapath #(
    .ENTRIES(ENTRIES), .MAX_SUBJECTS(MAX_SUBJECTS), .MAX_OBJECTS(MAX_OBJECTS)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mode_i(s_axis_tdata[2:0]), .subject_index_i(s_axis_tdata[6:3]),
    .object_index_i(s_axis_tdata[10:7]), .rights_mask_i(s_axis_tdata[12:11]),
    .cmd_i(cmd), .sts_o(sts),
    .status_o(status), .subject_out_o(subj_out), .row_count_o(rows),
    .cell_count_o(cells), .filled_count_o(filled), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, filled, cells, rows, subj_out, status};

endmodule

/* sv/art_checker.sv */
// Port-level checker for access_rights_table_unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module art_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  // no new command while a result is pending
  `ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  // stalled result holds
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata))
  // results whose status is not done carry last
  `ASSERT_IMPL(a_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1:0] != 2'd0,
               m_axis_tlast)
  // an accepted command is not followed at once by a result
  `ASSERT_NEXT(a_lat, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
endmodule

bind access_rights_table_unit art_checker u_chk (.*);

/* bench/tb_top.sv */
// Self-checking bench for access_rights_table_unit: drives random and directed
// commands, predicts results with a behavioral copy of the table, and compares.
// Depends on art_pkg and the access_rights_table_unit RTL.
`timescale 1ns / 100ps

module tb_top;
  import art_pkg::*;

  localparam int unsigned N_ENT  = 64;
  localparam int unsigned N_SUBJ = 16;
  localparam int unsigned N_OBJ  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 200;

  typedef struct packed {
    logic [1:0] rights;
    logic [3:0] obj;
    logic [3:0] subj;
    logic [2:0] mode;
  } cmd_t;

  typedef struct packed {
    logic       last;
    logic [6:0] filled;
    logic [8:0] cells;
    logic [4:0] rows;
    logic [4:0] subj;
    logic [1:0] status;
  } resp_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = CFG_INIT_SUBJ;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;
  logic             m_axis_tlast;

  access_rights_table_unit u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the table
  logic [3:0] tbl_subj [N_ENT];
  logic [3:0] tbl_obj [N_ENT];
  logic [1:0] tbl_rights [N_ENT];
  int unsigned tbl_count;
  logic [N_SUBJ-1:0] gone_subj;
  int unsigned added_cnt;
  int unsigned init_subj_cfg;
  int unsigned obj_cnt_cfg;

  cmd_t  cmd_q [$];
  resp_t resp_q [$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_recv = 0;
  int unsigned idle_cycles = 0;

  function automatic int unsigned subject_total();
    int unsigned t;
    t = init_subj_cfg + added_cnt;
    return (t > N_SUBJ) ? N_SUBJ : t;
  endfunction

  function automatic int find_cell(logic [3:0] s, logic [3:0] o);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_subj[i] == s && tbl_obj[i] == o) return i;
    return -1;
  endfunction

  function automatic void drop_cell(int unsigned k);
    for (int unsigned i = k; i + 1 < tbl_count; i++) begin
      tbl_subj[i]   = tbl_subj[i+1];
      tbl_obj[i]    = tbl_obj[i+1];
      tbl_rights[i] = tbl_rights[i+1];
    end
    tbl_count--;
  endfunction

  function automatic void push_resp(logic [1:0] st, int unsigned s, int unsigned r,
                                    int unsigned c, int unsigned f, bit l);
    resp_t e;
    e.status = st; e.subj = s[4:0]; e.rows = r[4:0];
    e.cells = c[8:0]; e.filled = f[6:0]; e.last = l;
    resp_q = {resp_q, e};
  endfunction

  // Append one command to the pending queue
  function automatic void queue_cmd(cmd_t c);
    cmd_q = {cmd_q, c};
  endfunction

  // Apply one command to the shadow table and queue its results
  function automatic void predict_table(cmd_t c);
    int k;
    int unsigned t, rows, objs, cells, n, i;
    bit any, dup;
    logic [3:0] seen [16];
    case (c.mode)
      MODE_ADD: begin
        k = find_cell(c.subj, c.obj);
        if (k >= 0) begin
          tbl_rights[k] |= c.rights;
          push_resp(ST_DONE, 0, 0, 0, 0, 1);
        end else if (c.subj < subject_total() && !gone_subj[c.subj]) begin
          if (c.rights == 2'b00) push_resp(ST_DONE, 0, 0, 0, 0, 1);
          else if (tbl_count >= N_ENT) push_resp(ST_FULL, 0, 0, 0, 0, 1);
          else begin
            tbl_subj[tbl_count] = c.subj;
            tbl_obj[tbl_count] = c.obj;
            tbl_rights[tbl_count] = c.rights;
            tbl_count++;
            push_resp(ST_NEW, 0, 0, 0, 0, 1);
          end
        end else push_resp(ST_NONE, 0, 0, 0, 0, 1);
      end
      MODE_REM: begin
        k = find_cell(c.subj, c.obj);
        if (k < 0) push_resp(ST_NONE, 0, 0, 0, 0, 1);
        else begin
          tbl_rights[k] &= ~c.rights;
          if (tbl_rights[k] == 2'b00) drop_cell(k);
          push_resp(ST_DONE, 0, 0, 0, 0, 1);
        end
      end
      MODE_NEW: begin
        t = subject_total();
        if (t >= N_SUBJ) push_resp(ST_FULL, t, 0, 0, 0, 1);
        else begin
          added_cnt = (added_cnt + 1) & 31;
          push_resp(ST_DONE, subject_total(), 0, 0, 0, 1);
        end
      end
      MODE_DEL: begin
        any = 0; i = 0;
        while (i < tbl_count) begin
          if (tbl_subj[i] == c.subj) begin
            drop_cell(i);
            any = 1;
          end else i++;
        end
        if (any) begin
          gone_subj[c.subj] = 1'b1;
          push_resp(ST_DONE, 0, 0, 0, 0, 1);
        end else push_resp(ST_NONE, 0, 0, 0, 0, 1);
      end
      MODE_OCC: begin
        rows = 0;
        for (i = 0; i < tbl_count; i++)
          if (tbl_subj[i] + 1 > rows) rows = tbl_subj[i] + 1;
        objs = (obj_cnt_cfg > N_OBJ) ? N_OBJ : obj_cnt_cfg;
        cells = rows * objs;
        if (cells > 511) cells = 511;
        push_resp(ST_DONE, 0, rows, cells, tbl_count, 1);
      end
      MODE_LIST: begin
        n = 0;
        for (i = 0; i < tbl_count && n < 16; i++) begin
          if (tbl_obj[i] != c.obj) continue;
          dup = 0;
          for (int j = 0; j < n; j++) if (seen[j] == tbl_subj[i]) dup = 1;
          if (!dup) begin
            seen[n] = tbl_subj[i];
            n++;
          end
        end
        if (n == 0) push_resp(ST_NONE, 0, 0, 0, 0, 1);
        for (i = 0; i < n; i++) push_resp(ST_DONE, seen[i], 0, 0, 0, i == n - 1);
      end
      default: push_resp(ST_NONE, 0, 0, 0, 0, 1);
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH transfer %0d %s: got %0d expected %0d", n_recv, what, got, want);
    errors++;
  endtask

  // Driver: bursts of transfers with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  cmd_t cur_cmd;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_table(cur_cmd);
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          s_axis_tdata <= {3'b000, cur_cmd};
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else burst_left--;
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: receiver stall pattern plus field compare
  logic [7:0] stall_pat = 8'hff;
  resp_t got, want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[28:0];
        got.last = m_axis_tlast;
        n_recv++;
        if (resp_q.size() == 0) report_mismatch("unexpected transfer", 1, 0);
        else begin
          want = resp_q.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.subj != want.subj) report_mismatch("subject_out", got.subj, want.subj);
          if (got.rows != want.rows) report_mismatch("row_count", got.rows, want.rows);
          if (got.cells != want.cells) report_mismatch("cell_count", got.cells, want.cells);
          if (got.filled != want.filled)
            report_mismatch("filled_count", got.filled, want.filled);
          if (got.last != want.last) report_mismatch("tlast", got.last, want.last);
          if (m_axis_tdata[31:29] != 3'b000) report_mismatch("pad bits", m_axis_tdata[31:29], 0);
        end
      end
      if ($urandom_range(0, 15) == 0)
        stall_pat <= ($urandom_range(0, 1) != 0) ? 8'hff : 8'($urandom);
      else
        stall_pat <= {stall_pat[6:0], stall_pat[7]};
      m_axis_tready <= stall_pat[0];
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", resp_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic cmd_t mk(logic [2:0] m, int unsigned s, int unsigned o, int unsigned r);
    cmd_t c;
    c.mode = m; c.subj = s[3:0]; c.obj = o[3:0]; c.rights = r[1:0];
    return c;
  endfunction

  task automatic wait_drained();
    while (cmd_q.size() > 0 || s_axis_tvalid || resp_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_INIT_SUBJ) init_subj_cfg = val; else obj_cnt_cfg = val;
  endtask

  // Random command mix: adds most often, some with subjects beyond the subject total
  task automatic random_phase(int unsigned n);
    int unsigned p;
    for (int unsigned i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 40) queue_cmd(mk(MODE_ADD, $urandom_range(0, 15) % (subject_total() + 2),
                               $urandom_range(0, 5), $urandom_range(0, 3)));
      else if (p < 55) queue_cmd(mk(MODE_REM, $urandom_range(0, 7),
                                    $urandom_range(0, 5), $urandom_range(0, 3)));
      else if (p < 63) queue_cmd(mk(MODE_NEW, 0, 0, 0));
      else if (p < 68) queue_cmd(mk(MODE_DEL, $urandom_range(0, 15), 0, 0));
      else if (p < 78) queue_cmd(mk(MODE_OCC, $urandom, $urandom, $urandom));
      else if (p < 95) queue_cmd(mk(MODE_LIST, $urandom, $urandom_range(0, 5), $urandom));
      else queue_cmd(mk(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    tbl_count = 0; gone_subj = '0; added_cnt = 0;
    init_subj_cfg = 2; obj_cnt_cfg = 2;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every mode and the corner cases
    queue_cmd(mk(MODE_OCC, 0, 0, 0));
    queue_cmd(mk(MODE_LIST, 0, 15, 0));
    queue_cmd(mk(MODE_ADD, 0, 15, 3));
    queue_cmd(mk(MODE_ADD, 0, 15, 1));
    queue_cmd(mk(MODE_ADD, 1, 0, 0));
    queue_cmd(mk(MODE_ADD, 15, 3, 2));
    queue_cmd(mk(MODE_ADD, 1, 15, 2));
    queue_cmd(mk(MODE_LIST, 0, 15, 0));
    queue_cmd(mk(MODE_REM, 1, 15, 1));
    queue_cmd(mk(MODE_REM, 1, 15, 2));
    queue_cmd(mk(MODE_REM, 7, 7, 3));
    queue_cmd(mk(MODE_OCC, 15, 15, 3));
    queue_cmd(mk(MODE_DEL, 0, 0, 0));
    queue_cmd(mk(MODE_DEL, 0, 0, 0));
    queue_cmd(mk(MODE_ADD, 0, 4, 1));
    queue_cmd(mk(MODE_NEW, 0, 0, 0));
    queue_cmd(mk(3'd6, 15, 15, 3));
    queue_cmd(mk(3'd7, 0, 0, 0));
    wait_drained();

    // Max subjects and objects: fill the store and list wide
    write_cfg(CFG_INIT_SUBJ, 16);
    write_cfg(CFG_OBJ_CNT, 16);
    queue_cmd(mk(MODE_NEW, 0, 0, 0));
    for (int unsigned i = 0; i < 66; i++) queue_cmd(mk(MODE_ADD, i % 16, i / 16, 3));
    queue_cmd(mk(MODE_OCC, 0, 0, 0));
    queue_cmd(mk(MODE_LIST, 0, 1, 0));
    queue_cmd(mk(MODE_DEL, 15, 0, 0));
    queue_cmd(mk(MODE_OCC, 0, 0, 0));
    random_phase(30);
    wait_drained();

    // Oversized object count, no initial subjects
    write_cfg(CFG_OBJ_CNT, 31);
    write_cfg(CFG_INIT_SUBJ, 0);
    queue_cmd(mk(MODE_OCC, 0, 0, 0));
    random_phase(40);
    wait_drained();

    write_cfg(CFG_OBJ_CNT, 1);
    write_cfg(CFG_INIT_SUBJ, $urandom_range(1, 31));
    random_phase(40);
    wait_drained();

    $display("covered %0d commands and %0d result transfers over four register settings",
             n_sent, n_recv);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* access_rights_table_unit.f */
+incdir+sv
sv/art_pkg.sv
sv/art_datapath.sv
sv/art_ctrl.sv
sv/access_rights_table_unit.sv
sv/art_checker.sv
bench/tb_top.sv
